[design/radix2_fft_frame_assert.svh]
// Assertion macros for the radix2_fft_frame checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef RADIX2_FFT_FRAME_ASSERT_SVH
`define RADIX2_FFT_FRAME_ASSERT_SVH

// holds on every rising clock edge outside reset
`define R2F_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent on the following edge
`define R2F_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/r2fft_pkg.sv]
// Types, constants and twiddle table for the radix-2 frame FFT.
// No dependencies.
package r2fft_pkg;

  localparam int Points = 128;
  localparam int Log2Pts = 7;
  localparam int TwN = Points / 2;
  localparam int SmpW = 16;
  localparam int BinW = 25;
  localparam int CoefW = 17;
  localparam int ProdW = BinW + CoefW;

  typedef logic [Log2Pts-1:0] addr_t;
  typedef logic signed [BinW-1:0] bin_t;
  typedef logic signed [CoefW-1:0] coef_t;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_LOAD = 12'b000000000010,
    ST_LDFL = 12'b000000000100,
    ST_RD   = 12'b000000001000,
    ST_M0   = 12'b000000010000,
    ST_M1   = 12'b000000100000,
    ST_M2   = 12'b000001000000,
    ST_M3   = 12'b000010000000,
    ST_M4   = 12'b000100000000,
    ST_WRA  = 12'b001000000000,
    ST_WRB  = 12'b010000000000,
    ST_DONE = 12'b100000000000
  } state_e;

  function automatic longint unsigned mul_q31(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 30)) >> 31;
  endfunction

  // {wr, wi} for twiddle index k, Q2.15 with 1.0 exact
  function automatic logic [2*CoefW-1:0] tw_calc(int k);
    longint unsigned q4, quad, r, x, x2, ts, tc, c, s, t, cq, sq;
    longint ss, cs, wr, wi;
    bit swap;
    q4 = 4 * k;
    quad = (q4 >> Log2Pts) & 3;
    r = q4 & (Points - 1);
    swap = (2 * r) > Points;
    if (swap) r = Points - r;
    x = (64'd3373259426 * r + TwN) >> Log2Pts;
    x2 = mul_q31(x, x);
    ts = x;
    tc = 64'd2147483648;
    ss = longint'(x);
    cs = longint'(tc);
    // Taylor terms, sin up to x^15 and cos up to x^14
    ts = mul_q31(ts, x2) / 6;
    tc = mul_q31(tc, x2) / 2;
    ss = ss - longint'(ts);
    cs = cs - longint'(tc);
    ts = mul_q31(ts, x2) / 20;
    tc = mul_q31(tc, x2) / 12;
    ss = ss + longint'(ts);
    cs = cs + longint'(tc);
    ts = mul_q31(ts, x2) / 42;
    tc = mul_q31(tc, x2) / 30;
    ss = ss - longint'(ts);
    cs = cs - longint'(tc);
    ts = mul_q31(ts, x2) / 72;
    tc = mul_q31(tc, x2) / 56;
    ss = ss + longint'(ts);
    cs = cs + longint'(tc);
    ts = mul_q31(ts, x2) / 110;
    tc = mul_q31(tc, x2) / 90;
    ss = ss - longint'(ts);
    cs = cs - longint'(tc);
    ts = mul_q31(ts, x2) / 156;
    tc = mul_q31(tc, x2) / 132;
    ss = ss + longint'(ts);
    cs = cs + longint'(tc);
    ts = mul_q31(ts, x2) / 210;
    tc = mul_q31(tc, x2) / 182;
    ss = ss - longint'(ts);
    cs = cs - longint'(tc);
    s = (ss < 0) ? 0 : longint'(ss);
    c = (cs < 0) ? 0 : longint'(cs);
    if (swap) begin
      t = c;
      c = s;
      s = t;
    end
    cq = (c + 32768) >> 16;
    sq = (s + 32768) >> 16;
    case (quad)
      0: begin wr = cq; wi = sq; end
      1: begin wr = -longint'(sq); wi = cq; end
      2: begin wr = -longint'(cq); wi = -longint'(sq); end
      default: begin wr = sq; wi = -longint'(cq); end
    endcase
    return {CoefW'(wr), CoefW'(wi)};
  endfunction

  function automatic logic [TwN*2*CoefW-1:0] tw_table();
    logic [TwN*2*CoefW-1:0] tab;
    tab = '0;
    for (int k = 0; k < TwN; k++) tab[k*2*CoefW +: 2*CoefW] = tw_calc(k);
    return tab;
  endfunction

  localparam logic [TwN*2*CoefW-1:0] TwTable = tw_table();

  function automatic addr_t bit_rev(addr_t v);
    addr_t r;
    for (int b = 0; b < Log2Pts; b++) r[b] = v[Log2Pts-1-b];
    return r;
  endfunction

  function automatic bin_t sat_bin(logic signed [BinW+3:0] v);
    if (v > (BinW+4)'(2**(BinW-1) - 1)) return {1'b0, {(BinW-1){1'b1}}};
    if (v < -(BinW+4)'(2**(BinW-1))) return {1'b1, {(BinW-1){1'b0}}};
    return v[BinW-1:0];
  endfunction

endpackage

[design/radix2_fft_frame.sv]
// Radix-2 DIT 128-point frame FFT: samples in, previous frame's bins out.
// Depends on r2fft_pkg. A bin word is read when its sample is taken and shows after
// the fetch and output registers; no sample is taken while a bin word is being fetched
// or a stalled one waits. After a frame's last sample the block is busy: it copies the
// frame in bit-reversed order, then runs 448 butterflies (states RD, M0-M4, WRA, WRB)
// through one shared 25x17 multiplier and a two-read-port work memory, then DONE.
// Reset clears the sample count and the valid flag; bins of the first frame read as 0.
module radix2_fft_frame (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           sample_real_i,
  input  logic signed [15:0]           sample_imag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [24:0]           bin_real_o,
  output logic signed [24:0]           bin_imag_o,
  output logic [6:0]                   bin_index_o,
  output logic                         bin_valid_o,
  output logic                         last_bin_o
);
  import r2fft_pkg::*;

  state_e st_q, st_d;
  addr_t cnt_q;
  logic [Log2Pts-2:0] j_q;
  logic [2:0] stage_q;
  logic have_q, fetch_q, out_valid_q, ld_v_q;
  addr_t f_idx_q, ld_dst_q;
  logic f_bv_q;
  logic [2*SmpW-1:0] samp_mem [Points];
  logic [2*BinW-1:0] work_mem [Points];
  logic [2*SmpW-1:0] ld_q;
  logic [2*BinW-1:0] rd_a_q, rd_b_q;
  coef_t wr_q, wi_q;
  logic signed [ProdW-1:0] p_q, acc_q;
  logic signed [BinW+2:0] tr_q, ti_q;
  bin_t out_re_q, out_im_q;
  logic out_last_q, out_bv_q;
  addr_t out_idx_q;

  logic accept;
  addr_t hmask, a_addr, b_addr, port_a;
  logic [Log2Pts-2:0] tw_idx;
  logic [2*CoefW-1:0] tw;
  bin_t op_x;
  coef_t op_y;
  logic signed [ProdW:0] sum;
  logic we;
  addr_t waddr;
  logic [2*BinW-1:0] wdata;
  bin_t ar, ai;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == ST_IDLE) && !fetch_q && (!out_valid_q || out_ready_i);

  assign hmask = (addr_t'(1) << stage_q) - addr_t'(1);
  assign a_addr = ((((addr_t'(j_q)) >> stage_q) << stage_q) << 1) | (addr_t'(j_q) & hmask);
  assign b_addr = a_addr | (addr_t'(1) << stage_q);
  assign tw_idx = (j_q & hmask[Log2Pts-2:0]) << (3'(Log2Pts - 1) - stage_q);
  assign tw = TwTable[tw_idx*2*CoefW +: 2*CoefW];
  assign port_a = (st_q == ST_IDLE) ? cnt_q : a_addr;
  assign ar = rd_a_q[BinW-1:0];
  assign ai = rd_a_q[2*BinW-1:BinW];

  always_comb begin
    op_x = rd_b_q[BinW-1:0];
    op_y = wr_q;
    case (st_q)
      ST_M1: begin op_x = rd_b_q[2*BinW-1:BinW]; op_y = wi_q; end
      ST_M2: begin op_x = rd_b_q[BinW-1:0]; op_y = wi_q; end
      ST_M3: begin op_x = rd_b_q[2*BinW-1:BinW]; op_y = wr_q; end
      default: ;
    endcase
  end

  always_comb begin
    if (st_q == ST_M2) sum = {acc_q[ProdW-1], acc_q} - {p_q[ProdW-1], p_q};
    else sum = {acc_q[ProdW-1], acc_q} + {p_q[ProdW-1], p_q};
    sum = sum + (ProdW+1)'(16384);
  end

  always_comb begin
    we = 1'b0;
    waddr = ld_dst_q;
    wdata = {BinW'(signed'(ld_q[2*SmpW-1:SmpW])), BinW'(signed'(ld_q[SmpW-1:0]))};
    case (st_q)
      ST_LOAD, ST_LDFL: we = ld_v_q;
      ST_WRA: begin
        we = 1'b1;
        waddr = a_addr;
        wdata = {sat_bin((BinW+4)'(ai) + (BinW+4)'(ti_q)),
                 sat_bin((BinW+4)'(ar) + (BinW+4)'(tr_q))};
      end
      ST_WRB: begin
        we = 1'b1;
        waddr = b_addr;
        wdata = {sat_bin((BinW+4)'(ai) - (BinW+4)'(ti_q)),
                 sat_bin((BinW+4)'(ar) - (BinW+4)'(tr_q))};
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (accept && cnt_q == addr_t'(Points - 1)) st_d = ST_LOAD;
      ST_LOAD: if (cnt_q == addr_t'(Points - 1)) st_d = ST_LDFL;
      ST_LDFL: st_d = ST_RD;
      ST_RD:   st_d = ST_M0;
      ST_M0:   st_d = ST_M1;
      ST_M1:   st_d = ST_M2;
      ST_M2:   st_d = ST_M3;
      ST_M3:   st_d = ST_M4;
      ST_M4:   st_d = ST_WRA;
      ST_WRA:  st_d = ST_WRB;
      ST_WRB: begin
        if (&j_q && stage_q == 3'(Log2Pts - 1)) st_d = ST_DONE;
        else st_d = ST_RD;
      end
      ST_DONE: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      cnt_q <= '0;
      j_q <= '0;
      stage_q <= '0;
      have_q <= 1'b0;
      fetch_q <= 1'b0;
      out_valid_q <= 1'b0;
      ld_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      fetch_q <= accept;
      if (fetch_q) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (accept || st_q == ST_LOAD) cnt_q <= cnt_q + addr_t'(1);
      ld_v_q <= (st_q == ST_LOAD);
      if (st_q == ST_LDFL) begin
        j_q <= '0;
        stage_q <= '0;
      end else if (st_q == ST_WRB) begin
        j_q <= j_q + 1'b1;
        if (&j_q) stage_q <= stage_q + 3'd1;
      end
      if (st_q == ST_DONE) have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) samp_mem[cnt_q] <= {sample_imag_i, sample_real_i};
    if (st_q == ST_LOAD) begin
      ld_q <= samp_mem[cnt_q];
      ld_dst_q <= bit_rev(cnt_q);
    end
    if (we) work_mem[waddr] <= wdata;
    if (accept || st_q == ST_RD) rd_a_q <= work_mem[port_a];
    if (st_q == ST_RD) begin
      rd_b_q <= work_mem[b_addr];
      wr_q <= tw[2*CoefW-1:CoefW];
      wi_q <= tw[CoefW-1:0];
    end
    if (accept) begin
      f_idx_q <= cnt_q;
      f_bv_q <= have_q;
    end
    if (fetch_q) begin
      out_re_q <= f_bv_q ? rd_a_q[BinW-1:0] : '0;
      out_im_q <= f_bv_q ? rd_a_q[2*BinW-1:BinW] : '0;
      out_idx_q <= f_idx_q;
      out_bv_q <= f_bv_q;
      out_last_q <= (f_idx_q == addr_t'(Points - 1));
    end
    p_q <= op_x * op_y;
    if (st_q == ST_M1 || st_q == ST_M3) acc_q <= p_q;
    if (st_q == ST_M2) tr_q <= sum[ProdW:15];
    if (st_q == ST_M4) ti_q <= sum[ProdW:15];
  end

  assign out_valid_o = out_valid_q;
  assign bin_real_o = out_re_q;
  assign bin_imag_o = out_im_q;
  assign bin_index_o = out_idx_q;
  assign bin_valid_o = out_bv_q;
  assign last_bin_o = out_last_q;

endmodule

[design/radix2_fft_frame_chk.sv]
// Port-level checker for radix2_fft_frame, bound into radix2_fft_frame.
// Depends on radix2_fft_frame_assert.svh.
`include "radix2_fft_frame_assert.svh"
module radix2_fft_frame_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [24:0] bin_real_o,
  input logic [24:0] bin_imag_o,
  input logic [6:0]  bin_index_o,
  input logic        bin_valid_o,
  input logic        last_bin_o
);
  `R2F_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(bin_real_o) && $stable(bin_index_o), "result word dropped or changed while stalled")
  `R2F_ASSERT_NEXT(a_word_out, in_valid_i && in_ready_o, ##1 out_valid_o, "no result word after a sample")
  `R2F_ASSERT(a_last, !out_valid_o || (last_bin_o == (bin_index_o == 7'd127)), "last_bin does not match index")
  `R2F_ASSERT(a_zero, !out_valid_o || bin_valid_o || (bin_real_o == 25'd0 && bin_imag_o == 25'd0), "nonzero bin before first frame")
  `R2F_ASSERT_NEXT(a_bv_keep, out_valid_o && bin_valid_o, !out_valid_o || bin_valid_o, "bin_valid fell")
endmodule

bind radix2_fft_frame radix2_fft_frame_chk u_chk (.*);
